/* hdl/color_correction_matrix_3x3_defines.svh */
// Assertion macros used by the color correction matrix merge RTL.
`ifndef COLOR_CORRECTION_MATRIX_3X3_DEFINES_SVH
`define COLOR_CORRECTION_MATRIX_3X3_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ccm_pkg.sv */
package ccm_pkg;

    // Field widths fixed by the pixel and register formats.
    localparam int PIX_W       = 8;
    localparam int NUM_CH      = 3;
    localparam int COEF_W      = 16;
    localparam int CFG_DATA_W  = NUM_CH * COEF_W;
    localparam int CFG_IDX_W   = 8;
    localparam int MASK_W      = NUM_CH;
    localparam int TOTAL_W     = 32;

    // One product is 9 bits unsigned-as-signed times a 16-bit coefficient.
    localparam int PROD_W      = PIX_W + 1 + COEF_W;
    // Three products need two more bits of headroom.
    localparam int SUM_W       = PROD_W + 2;

    // Parameter defaults.
    localparam int DEF_COEF_FRAC_BITS = 12;
    localparam int DEF_COUNT_WIDTH    = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW2 = CFG_IDX_W'(2);

    // Reset values give the identity matrix in Q4.12.
    localparam logic [CFG_DATA_W-1:0] COEF_ROW0_RST = CFG_DATA_W'(48'h0000_0000_1000);
    localparam logic [CFG_DATA_W-1:0] COEF_ROW1_RST = CFG_DATA_W'(48'h0000_1000_0000);
    localparam logic [CFG_DATA_W-1:0] COEF_ROW2_RST = CFG_DATA_W'(48'h1000_0000_0000);

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [CFG_DATA_W-1:0]    t_coef_row;

    // Pipeline load enables handed to each lane.
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_lane_ctrl;

    // What one lane produces for its output channel.
    typedef struct packed {
        t_pix val;
        logic hi;
        logic lo;
    } t_lane_res;

endpackage

/* hdl/ccm_if.sv */
// Pixel input channel.
interface ccm_pix_if;
    import ccm_pkg::*;

    logic valid;
    logic ready;
    t_pix in_ch0;
    t_pix in_ch1;
    t_pix in_ch2;

    modport source (output valid, output in_ch0, output in_ch1, output in_ch2, input ready);
    modport sink   (input valid, input in_ch0, input in_ch1, input in_ch2, output ready);
endinterface

// Corrected pixel result channel.
interface ccm_res_if;
    import ccm_pkg::*;

    logic                valid;
    logic                ready;
    t_pix                out_ch0;
    t_pix                out_ch1;
    t_pix                out_ch2;
    logic [MASK_W-1:0]   high_mask;
    logic [MASK_W-1:0]   low_mask;
    logic [TOTAL_W-1:0]  high_total;
    logic [TOTAL_W-1:0]  low_total;

    modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                    output high_mask, output low_mask, output high_total,
                    output low_total, input ready);
    modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
                    input high_mask, input low_mask, input high_total,
                    input low_total, output ready);
endinterface

// Register write channel.
interface ccm_cfg_if;
    import ccm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/ccm_lane.sv */
module ccm_lane #(
    parameter int COEF_FRAC_BITS = ccm_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  ccm_pkg::t_lane_ctrl   i_ctrl,
    input  ccm_pkg::t_pix         i_pix  [ccm_pkg::NUM_CH],
    input  ccm_pkg::t_coef        i_coef [ccm_pkg::NUM_CH],
    output ccm_pkg::t_lane_res    o_res
);
    import ccm_pkg::*;

    // Largest in-range sum: 255.0 in the coefficient's fixed-point scale.
    localparam t_sum TOP = t_sum'(255) <<< COEF_FRAC_BITS;

    t_prod     r_prod [NUM_CH];
    t_lane_res r_res;
    t_sum      w_sum;
    t_lane_res n_res;

    // Stage one: one multiplier per input channel.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            for (int j = 0; j < NUM_CH; j++) begin
                r_prod[j] <= t_prod'($signed({1'b0, i_pix[j]})) * t_prod'(i_coef[j]);
            end
        end
    end

    // Stage two: sum, floor and clamp.
    always_comb begin
        w_sum = t_sum'(r_prod[0]) + t_sum'(r_prod[1]) + t_sum'(r_prod[2]);
        n_res.hi  = 1'b0;
        n_res.lo  = 1'b0;
        n_res.val = PIX_W'(w_sum >>> COEF_FRAC_BITS);
        if (w_sum > TOP) begin
            n_res.hi  = 1'b1;
            n_res.val = '1;
        end else if (w_sum < 0) begin
            n_res.lo  = 1'b1;
            n_res.val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sum) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* hdl/ccm_merge.sv */
`include "color_correction_matrix_3x3_defines.svh"

module ccm_merge #(
    parameter int COUNT_WIDTH = ccm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_take,
    input  ccm_pkg::t_lane_res    i_lane [ccm_pkg::NUM_CH],
    ccm_res_if.source             o_res
);
    import ccm_pkg::*;

    localparam int EXT_W = COUNT_WIDTH + TOTAL_W;

    logic                   r_valid;
    t_lane_res              r_out [NUM_CH];
    logic [COUNT_WIDTH-1:0] r_high_cnt;
    logic [COUNT_WIDTH-1:0] r_low_cnt;
    logic [COUNT_WIDTH-1:0] n_high_cnt;
    logic [COUNT_WIDTH-1:0] n_low_cnt;
    logic [1:0]             w_high_inc;
    logic [1:0]             w_low_inc;
    logic [COUNT_WIDTH:0]   w_high_sum;
    logic [COUNT_WIDTH:0]   w_low_sum;
    logic [MASK_W-1:0]      w_hmask;
    logic [MASK_W-1:0]      w_lmask;
    logic [EXT_W-1:0]       w_high_ext;
    logic [EXT_W-1:0]       w_low_ext;

    // The output register takes a new result when it is empty or being drained.
    assign o_take = !r_valid || o_res.ready;

    // Count the clipped channels of the incoming pixel and saturate.
    always_comb begin
        w_high_inc = 2'(i_lane[0].hi) + 2'(i_lane[1].hi) + 2'(i_lane[2].hi);
        w_low_inc  = 2'(i_lane[0].lo) + 2'(i_lane[1].lo) + 2'(i_lane[2].lo);
        w_high_sum = {1'b0, r_high_cnt} + (COUNT_WIDTH+1)'(w_high_inc);
        w_low_sum  = {1'b0, r_low_cnt} + (COUNT_WIDTH+1)'(w_low_inc);
        n_high_cnt = w_high_sum[COUNT_WIDTH] ? '1 : w_high_sum[COUNT_WIDTH-1:0];
        n_low_cnt  = w_low_sum[COUNT_WIDTH] ? '1 : w_low_sum[COUNT_WIDTH-1:0];
    end

    // Output register and running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_high_cnt <= '0;
            r_low_cnt  <= '0;
        end else if (o_take) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_high_cnt <= n_high_cnt;
                r_low_cnt  <= n_low_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_out <= i_lane;
        end
    end

    // Drive the result channel.
    always_comb begin
        w_hmask    = {r_out[2].hi, r_out[1].hi, r_out[0].hi};
        w_lmask    = {r_out[2].lo, r_out[1].lo, r_out[0].lo};
        w_high_ext = EXT_W'(r_high_cnt);
        w_low_ext  = EXT_W'(r_low_cnt);
    end

    assign o_res.valid      = r_valid;
    assign o_res.out_ch0    = r_out[0].val;
    assign o_res.out_ch1    = r_out[1].val;
    assign o_res.out_ch2    = r_out[2].val;
    assign o_res.high_mask  = w_hmask;
    assign o_res.low_mask   = w_lmask;
    assign o_res.high_total = w_high_ext[TOTAL_W-1:0];
    assign o_res.low_total  = w_low_ext[TOTAL_W-1:0];

    // Counters move only when a result enters the output register.
    `CCM_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !o_take, $stable(r_high_cnt) && $stable(r_low_cnt), "clip counter moved while stalled")
    // Counters never go down outside reset.
    `CCM_ASSERT_NEXT(a_cnt_mono, i_clk, i_rst_n, 1'b1, (r_high_cnt >= $past(r_high_cnt)) && (r_low_cnt >= $past(r_low_cnt)), "clip counter decreased")
    // A channel cannot be clipped high and low at once.
    `CCM_ASSERT_IMPL(a_clip_excl, i_clk, i_rst_n, r_valid, (w_hmask & w_lmask) == '0, "channel clipped both ways")
    // A high-clipped channel 0 reads full scale.
    `CCM_ASSERT_IMPL(a_clip_val, i_clk, i_rst_n, r_valid && r_out[0].hi, r_out[0].val == '1, "high clip without full scale")

endmodule

/* hdl/color_correction_matrix_3x3.sv */
// A pixel passes the lane multiply register, the lane sum register and the merge output register.
// Throughput: one pixel per cycle; three multiplier lanes and a merge register.
// Stalls on the result side back up through the two lane stages to the input.
// Reset (synchronous, active low) clears the pipeline, zeros both clip counters
// and loads the identity matrix into the coefficient registers.
module color_correction_matrix_3x3 #(
    parameter int COEF_FRAC_BITS = ccm_pkg::DEF_COEF_FRAC_BITS,
    parameter int COUNT_WIDTH    = ccm_pkg::DEF_COUNT_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccm_pix_if.sink    i_pix,
    ccm_cfg_if.sink    i_cfg,
    ccm_res_if.source  o_res
);
    import ccm_pkg::*;

    t_coef_row   r_coef_row [NUM_CH];
    logic        r_s1_valid;
    logic        r_s2_valid;
    logic        w_take;
    logic        w_s2_free;
    logic        w_s1_free;
    t_lane_ctrl  w_ctrl;
    t_pix        w_pix [NUM_CH];
    t_lane_res   w_lane [NUM_CH];

    // Coefficient registers; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_row[0] <= COEF_ROW0_RST;
            r_coef_row[1] <= COEF_ROW1_RST;
            r_coef_row[2] <= COEF_ROW2_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COEF_ROW0: r_coef_row[0] <= i_cfg.data;
                CFG_COEF_ROW1: r_coef_row[1] <= i_cfg.data;
                CFG_COEF_ROW2: r_coef_row[2] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when it is empty or moving on.
    assign w_s2_free   = !r_s2_valid || w_take;
    assign w_s1_free   = !r_s1_valid || w_s2_free;
    assign w_ctrl      = '{en_mul: w_s1_free, en_sum: w_s2_free};
    assign i_pix.ready = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_pix.valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    assign w_pix[0] = i_pix.in_ch0;
    assign w_pix[1] = i_pix.in_ch1;
    assign w_pix[2] = i_pix.in_ch2;

    // One lane per output channel, fed by that channel's matrix column.
    for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
        t_coef w_col [NUM_CH];

        for (genvar j = 0; j < NUM_CH; j++) begin : g_col
            assign w_col[j] = t_coef'(r_coef_row[j][k*COEF_W +: COEF_W]);
        end

        ccm_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_pix  (w_pix),
            .i_coef (w_col),
            .o_res  (w_lane[k])
        );
    end

    // Merge lane results, update clip totals and hold the result.
    ccm_merge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .o_take  (w_take),
        .i_lane  (w_lane),
        .o_res   (o_res)
    );

endmodule

/* test/tb_color_correction_matrix_3x3.sv */
module tb_color_correction_matrix_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import ccm_pkg::*;

    localparam int     FRAC_BITS   = DEF_COEF_FRAC_BITS;
    localparam longint CLIP_TOP    = longint'(255) << FRAC_BITS;
    localparam longint COUNT_MAX   = (longint'(1) << DEF_COUNT_WIDTH) - 1;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     MAX_IDLE    = 19;
    localparam int     DRAIN_WAIT  = 10;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 65;

    // First register index that maps to no coefficient row.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_COEF_ROW2 + 1'b1;

    // One corrected pixel with its clip flags and running totals.
    typedef struct {
        t_pix               ch[NUM_CH];
        logic [MASK_W-1:0]  hi;
        logic [MASK_W-1:0]  lo;
        logic [TOTAL_W-1:0] hi_total;
        logic [TOTAL_W-1:0] lo_total;
    } t_pixel_result;

    logic i_clk;
    logic i_rst_n;

    ccm_pix_if pix ();
    ccm_cfg_if cfg ();
    ccm_res_if res ();

    color_correction_matrix_3x3 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Local copy of the matrix and clip counters.
    t_coef_row     coef_rows[NUM_CH];
    longint        high_clips;
    longint        low_clips;
    t_pixel_result corrected_q[$];

    int  errors;
    int  cycles;
    bit  tx_gaps;
    bit  rx_stalls;

    // Clock generation.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run length guard.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Multiply a pixel by the matrix, clamp, and update the clip counters.
    function automatic t_pixel_result correct_pixel(t_pix p0, t_pix p1, t_pix p2);
        t_pixel_result r;
        t_pix          px[NUM_CH];
        t_coef         c;
        longint        sum;
        longint        hcnt;
        longint        lcnt;
        px   = '{p0, p1, p2};
        hcnt = 0;
        lcnt = 0;
        r.hi = '0;
        r.lo = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            sum = 0;
            for (int j = 0; j < NUM_CH; j++) begin
                c   = coef_rows[j][k*COEF_W +: COEF_W];
                sum += longint'(px[j]) * longint'(c);
            end
            if (sum > CLIP_TOP) begin
                r.ch[k] = 8'd255;
                r.hi[k] = 1'b1;
                hcnt++;
            end else if (sum < 0) begin
                r.ch[k] = 8'd0;
                r.lo[k] = 1'b1;
                lcnt++;
            end else begin
                r.ch[k] = t_pix'(sum >>> FRAC_BITS);
            end
        end
        high_clips = (high_clips + hcnt > COUNT_MAX) ? COUNT_MAX : high_clips + hcnt;
        low_clips  = (low_clips + lcnt > COUNT_MAX) ? COUNT_MAX : low_clips + lcnt;
        r.hi_total = high_clips[TOTAL_W-1:0];
        r.lo_total = low_clips[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [TOTAL_W-1:0] exp_val,
                               logic [TOTAL_W-1:0] act_val);
        if (act_val !== exp_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, exp_val, act_val);
        end
    endtask

    // Check each result transfer, then predict from each pixel or register transfer.
    always @(posedge i_clk) begin
        t_pixel_result exp_res;
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                if (corrected_q.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing expected", $realtime);
                end else begin
                    exp_res = corrected_q.pop_front();
                    check_field("out_ch0", exp_res.ch[0], res.out_ch0);
                    check_field("out_ch1", exp_res.ch[1], res.out_ch1);
                    check_field("out_ch2", exp_res.ch[2], res.out_ch2);
                    check_field("high_mask", exp_res.hi, res.high_mask);
                    check_field("low_mask", exp_res.lo, res.low_mask);
                    check_field("high_total", exp_res.hi_total, res.high_total);
                    check_field("low_total", exp_res.lo_total, res.low_total);
                end
            end
            if (cfg.valid && cfg.ready && cfg.index < NUM_CH)
                coef_rows[cfg.index] = cfg.data;
            if (pix.valid && pix.ready)
                corrected_q.push_back(correct_pixel(pix.in_ch0, pix.in_ch1, pix.in_ch2));
        end
    end

    // Result side: random stalls, switched on and off in stretches.
    initial begin
        int stall;
        res.ready <= 1'b0;
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_stalls = !rx_stalls;
            stall = rx_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
        end
    end

    // Send one pixel; valid stays high into the next call when no gap is drawn.
    task automatic send_pixel(t_pix p0, t_pix p1, t_pix p2);
        int gap;
        gap = tx_gaps ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid  <= 1'b1;
        pix.in_ch0 <= p0;
        pix.in_ch1 <= p1;
        pix.in_ch2 <= p2;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // Stop sending and wait until every expected result has arrived.
    // It waits for a clock edge first so that the last pixel transfer is already predicted.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (corrected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; the caller lowers valid after the last one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_coef_row data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
    endtask

    task automatic load_matrix(t_coef_row r0, t_coef_row r1, t_coef_row r2);
        write_reg(CFG_COEF_ROW0, r0);
        write_reg(CFG_COEF_ROW1, r1);
        write_reg(CFG_COEF_ROW2, r2);
        cfg.valid <= 1'b0;
    endtask

    // Random coefficient row: plausible color matrix, mild spread, or any bits.
    function automatic t_coef_row random_row(int row);
        t_coef_row r;
        int        kind;
        kind = $urandom_range(0, 3);
        for (int k = 0; k < NUM_CH; k++) begin
            case (kind)
                0: begin
                    r[k*COEF_W +: COEF_W] = COEF_W'($urandom);
                end
                1: begin
                    r[k*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
                end
                default: begin
                    if (k == row)
                        r[k*COEF_W +: COEF_W] = COEF_W'(4096 + int'($urandom_range(0, 3072)) - 1536);
                    else
                        r[k*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(0, 2048)) - 1024);
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_pix random_channel();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return t_pix'($urandom);
    endfunction

    // Reset matrix is the identity, so every pixel comes back unchanged.
    task automatic test_identity_reset();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'h55, 8'hAA, 8'h0F);
        send_pixel(8'hAA, 8'h55, 8'hF0);
        send_pixel(8'd1, 8'd128, 8'd254);
    endtask

    // Fractional overflow, small negative sums and ordinary in-range values.
    task automatic test_clip_cases();
        wait_idle();
        load_matrix({16'h7FFF, 16'hFC00, 16'h1001},
                    {16'h8000, 16'h0000, 16'h0000},
                    {16'h0000, 16'h0800, 16'h0000});
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd2);
        send_pixel(8'd0, 8'd0, 8'd255);
    endtask

    // Largest positive, most negative and all-zero coefficients.
    task automatic test_extreme_matrices();
        t_coef_row rows[3];
        rows = '{48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0};
        foreach (rows[i]) begin
            wait_idle();
            load_matrix(rows[i], rows[i], rows[i]);
            send_pixel(8'd255, 8'd255, 8'd255);
            send_pixel(8'd0, 8'd0, 8'd0);
            send_pixel(8'd1, 8'd1, 8'd1);
        end
    endtask

    // Writes to indexes past the last row must leave the matrix alone.
    task automatic test_unused_index();
        wait_idle();
        write_reg(CFG_COEF_ROW0, 48'h0000_0000_1000);
        write_reg(CFG_COEF_ROW1, 48'h0000_1000_0000);
        write_reg(CFG_COEF_ROW2, 48'h1000_0000_0000);
        write_reg(CFG_FIRST_UNUSED, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 255)), 48'h8000_8000_8000);
        cfg.valid <= 1'b0;
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd255, 8'd0, 8'd255);
    endtask

    // Random pixels over several random matrices with mixed flow control.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_idle();
            load_matrix(random_row(0), random_row(1), random_row(2));
            tx_gaps   = (phase < 4) ? phase[0] : $urandom_range(0, 1);
            rx_stalls = (phase < 4) ? phase[1] : $urandom_range(0, 1);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 15) == 0)
                    tx_gaps = !tx_gaps;
                send_pixel(random_channel(), random_channel(), random_channel());
            end
        end
    endtask

    // Main sequence.
    initial begin
        errors     = 0;
        cycles     = 0;
        tx_gaps    = 1'b1;
        rx_stalls  = 1'b1;
        coef_rows  = '{COEF_ROW0_RST, COEF_ROW1_RST, COEF_ROW2_RST};
        high_clips = 0;
        low_clips  = 0;
        i_rst_n    <= 1'b0;
        pix.valid  <= 1'b0;
        pix.in_ch0 <= '0;
        pix.in_ch1 <= '0;
        pix.in_ch2 <= '0;
        cfg.valid  <= 1'b0;
        cfg.index  <= '0;
        cfg.data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_reset();
        test_clip_cases();
        test_extreme_matrices();
        test_unused_index();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
